/* sv/rcmr_pkg.sv */
// ----------------------------------------------------------------------------
// rcmr_pkg
// shared constants and types for the rod cutting revenue solver
// ----------------------------------------------------------------------------
package rcmr_pkg;

  // default sizing
  localparam int MAX_LEN_DEF    = 64;
  localparam int PRICE_BITS_DEF = 16;

  // fixed field widths
  localparam int LEN_W   = 7;
  localparam int PRICE_W = 16;
  localparam int REV_W   = 22;

  localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // control of the shared add-compare unit
  typedef struct packed {
    logic clr;  // restart the running maximum at zero
    logic en;   // fold in the candidate from this cycle's read data
  } acu_ctl_t;

endpackage

/* sv/rcmr_ram.sv */
// ----------------------------------------------------------------------------
// rcmr_ram
// single write port, single registered read port table storage
// ----------------------------------------------------------------------------
module rcmr_ram
  import rcmr_pkg::*;
#(
  parameter int DEPTH = MAX_LEN_DEF,
  parameter int AW    = $clog2(MAX_LEN_DEF),
  parameter int DW    = PRICE_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rcmr_acu.sv */
// ----------------------------------------------------------------------------
// rcmr_acu
// shared saturating add and running maximum
// ----------------------------------------------------------------------------
module rcmr_acu
  import rcmr_pkg::*;
#(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  acu_ctl_t              ctl,
  input  logic [PRICE_BITS-1:0] price_rd,
  input  logic [REV_W-1:0]      best_rd,
  output logic [REV_W-1:0]      q
);

  localparam int SUM_W = ((PRICE_BITS > REV_W) ? PRICE_BITS : REV_W) + 1;

  logic [SUM_W-1:0] sum;
  logic [REV_W-1:0] cand;
  logic [REV_W-1:0] q_r;
  logic [REV_W-1:0] q_nxt;

  always_comb begin
    sum  = SUM_W'(price_rd) + SUM_W'(best_rd);
    // clip to the result range
    cand = (sum > SUM_W'(REV_MAX)) ? REV_MAX : sum[REV_W-1:0];
    q_nxt = q_r;
    if (ctl.clr) begin
      q_nxt = '0;
    end else if (ctl.en && (cand > q_r)) begin
      q_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

/* sv/rod_cutting_max_revenue.sv */
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue
// bottom-up rod cutting solver: price table loads and best revenue solves
// ----------------------------------------------------------------------------
// flow: a load beat is written to the price table as it is accepted; a solve of rod
//   length n fills revenue rows 1..n in turn, then gives best[n] as its result beat
// throughput: one add-compare per cycle through a single shared unit while a row is
//   issued, one price read and one revenue read per step; while idle, a load can follow every cycle
// reset: synchronous active-low; afterwards a clearing pass zeroes every entry
//   of the price table, and no input beat is taken until it ends
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue
  import rcmr_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [LEN_W-1:0]   in_length,
  input  logic [PRICE_W-1:0] in_price,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [REV_W-1:0]   out_best_revenue
);

  // j counts 0..MAX_LEN, price table holds lengths 1..MAX_LEN at 0..MAX_LEN-1
  localparam int J_W  = $clog2(MAX_LEN + 1);
  localparam int PA_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // sequencer states
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,  // zero the price table after reset
    S_IDLE  = 7'b0000010,  // take loads and solves
    S_START = 7'b0000100,  // seed best[0] and the loop counters
    S_ISSUE = 7'b0001000,  // read price[i-1] and best[j-i], one step per cycle
    S_DRAIN = 7'b0010000,  // last read of this row reaches the unit
    S_WRITE = 7'b0100000,  // store best[j], move to the next row
    S_DONE  = 7'b1000000   // hand best[n] to the output register
  } state_t;

  state_t state_r, state_nxt;

  logic [J_W-1:0] n_r, n_nxt;      // rod length being solved
  logic [J_W-1:0] j_r, j_nxt;      // row of the revenue table
  logic [J_W-1:0] i_r, i_nxt;      // piece length tried for row j
  logic [J_W-1:0] clr_r, clr_nxt;  // clearing pass address
  logic           issued_r;        // a read pair went out last cycle

  logic             out_valid_r, out_valid_nxt;
  logic [REV_W-1:0] out_best_r;
  logic             out_load;

  // price table ports
  logic                  pw_we;
  logic [PA_W-1:0]       pw_addr;
  logic [PRICE_BITS-1:0] pw_data;
  logic [PA_W-1:0]       pr_addr;
  logic [PRICE_BITS-1:0] pr_data;

  // revenue table ports
  logic             bw_we;
  logic [J_W-1:0]   bw_addr;
  logic [REV_W-1:0] bw_data;
  logic [J_W-1:0]   br_addr;
  logic [REV_W-1:0] br_data;

  acu_ctl_t         acu_ctl;
  logic [REV_W-1:0] acu_q;

  // load decode
  logic             in_accept;
  logic             load_ok;
  logic [LEN_W-1:0] load_m1;
  logic [J_W-1:0]   solve_len;
  logic [J_W-1:0]   i_m1;

  assign in_accept = in_valid && !in_stall;
  assign load_m1   = in_length - LEN_W'(1);
  // a load of length zero or past the table is dropped
  assign load_ok   = (in_length != '0) && (32'(in_length) <= MAX_LEN);
  // solve lengths past the table clip to the largest length
  assign solve_len = (32'(in_length) > MAX_LEN) ? J_W'(MAX_LEN) : J_W'(in_length);
  assign i_m1      = i_r - J_W'(1);

  // read addresses follow the loop counters directly
  assign pr_addr = i_m1[PA_W-1:0];
  assign br_addr = j_r - i_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    clr_nxt       = clr_r;
    pw_we         = 1'b0;
    pw_addr       = PA_W'(load_m1);
    pw_data       = PRICE_BITS'(in_price);
    bw_we         = 1'b0;
    bw_addr       = j_r;
    bw_data       = acu_q;
    acu_ctl.clr   = 1'b0;
    acu_ctl.en    = issued_r;
    out_load      = 1'b0;
    // result beat leaves when the sink takes it
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_CLEAR: begin
        pw_we   = 1'b1;
        pw_addr = clr_r[PA_W-1:0];
        pw_data = '0;
        if (clr_r == J_W'(MAX_LEN - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + J_W'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_LOAD) begin
            pw_we = load_ok;
          end else begin
            n_nxt     = solve_len;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        // best[0] = 0, and the running max starts at zero
        bw_we       = 1'b1;
        bw_addr     = '0;
        bw_data     = '0;
        acu_ctl.clr = 1'b1;
        j_nxt       = J_W'(1);
        i_nxt       = J_W'(1);
        state_nxt   = (n_r == '0) ? S_DONE : S_ISSUE;
      end
      S_ISSUE: begin
        if (i_r == j_r) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + J_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        // row j is final; later rows read it from here on
        bw_we = 1'b1;
        if (j_r == n_r) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt       = j_r + J_W'(1);
          i_nxt       = J_W'(1);
          acu_ctl.clr = 1'b1;
          state_nxt   = S_ISSUE;
        end
      end
      S_DONE: begin
        // the unit still holds best[n]; wait for a free output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      n_r         <= '0;
      j_r         <= '0;
      i_r         <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      n_r         <= n_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
      issued_r    <= (state_r == S_ISSUE);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_r <= acu_q;
    end
  end

  // only the idle state takes beats
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_best_revenue = out_best_r;

  // price table, zeroed by the clearing pass
  rcmr_ram #(
    .DEPTH (MAX_LEN),
    .AW    (PA_W),
    .DW    (PRICE_BITS)
  ) u_price_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (pr_addr),
    .rdata (pr_data)
  );

  // revenue table, every entry written before it is read in a solve
  rcmr_ram #(
    .DEPTH (MAX_LEN + 1),
    .AW    (J_W),
    .DW    (REV_W)
  ) u_best_ram (
    .clk   (clk),
    .we    (bw_we),
    .waddr (bw_addr),
    .wdata (bw_data),
    .raddr (br_addr),
    .rdata (br_data)
  );

  // shared add-compare unit
  rcmr_acu #(
    .PRICE_BITS (PRICE_BITS)
  ) u_acu (
    .clk      (clk),
    .ctl      (acu_ctl),
    .price_rd (pr_data),
    .best_rd  (br_data),
    .q        (acu_q)
  );

  // loop indices stay inside the triangle 1 <= i <= j <= n
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> ((i_r != '0) && (i_r <= j_r) && (j_r <= n_r)))
    else $error("solve step outside 1 <= i <= j <= n");

  // a new result beat only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && out_valid_nxt |-> (state_r == S_DONE))
    else $error("result beat loaded outside the done state");

  // the last row leads straight to the done state
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) && (j_r == n_r) |=> (state_r == S_DONE))
    else $error("last row did not finish the solve");

  // every row starts with no read of the previous row still in flight
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) && (i_r == J_W'(1)) |-> !issued_r)
    else $error("row started while a read was still in flight");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rod cutting best revenue solver: price loads
// and solves are driven through the valid/stall input channel, an in-bench
// dynamic programming predictor works out each solve's best revenue, and a
// checker compares every result beat against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
  import rcmr_pkg::*;

  localparam int MAX_LEN        = MAX_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 10000;  // well above a full-length solve
  localparam int DRAIN_CYCLES   = 20;
  localparam int SHOW_LIMIT     = 10;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [LEN_W-1:0]   in_length;
  logic [PRICE_W-1:0] in_price;
  logic               out_valid;
  logic               out_stall;
  logic [REV_W-1:0]   out_best_revenue;

  // predictor state: price of each piece length, index 1..MAX_LEN
  logic [PRICE_W-1:0] price_tab [1:MAX_LEN];
  // best revenues still owed by the block, oldest first
  logic [REV_W-1:0]   revenue_q [$];

  int unsigned fail_count  = 0;
  int unsigned n_loads     = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_solves    = 0;
  int unsigned n_checked   = 0;
  int unsigned longest_rod = 0;
  int unsigned idle_cycles = 0;

  // receiver controls: a requested hold-off length, and a no-stall mode
  int unsigned hold_req = 0;
  bit          no_idle  = 1'b0;

  rod_cutting_max_revenue u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_length        (in_length),
    .in_price         (in_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_best_revenue (out_best_revenue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bottom-up rod cutting over the current price table; the rod length
  // saturates at MAX_LEN and each sum saturates at the revenue width
  function automatic logic [REV_W-1:0] best_revenue_for(input int unsigned rod_len);
    logic [REV_W-1:0] rev [0:MAX_LEN];
    logic [REV_W:0]   cand;
    logic [REV_W-1:0] q;
    int unsigned      n;
    n = (rod_len > MAX_LEN) ? MAX_LEN : rod_len;
    rev[0] = '0;
    for (int j = 1; j <= n; j++) begin
      q = '0;
      for (int i = 1; i <= j; i++) begin
        cand = {1'b0, {(REV_W-PRICE_W){1'b0}}, price_tab[i]} + {1'b0, rev[j-i]};
        if (cand > {1'b0, REV_MAX}) cand = {1'b0, REV_MAX};
        if (cand[REV_W-1:0] > q) q = cand[REV_W-1:0];
      end
      rev[j] = q;
    end
    return rev[n];
  endfunction

  // offer one beat and hold it until taken; the model is updated at acceptance.
  // valid is left high so a following beat can go out in the next cycle
  task automatic send_beat(input logic cmd, input logic [LEN_W-1:0] len,
                           input logic [PRICE_W-1:0] px);
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_length <= len;
    in_price  <= px;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (cmd == CMD_LOAD) begin
      // loads of length zero or past the table are dropped by the block
      if (len >= 1 && len <= MAX_LEN) begin
        price_tab[len] = px;
        n_loads++;
      end else begin
        n_ignored++;
      end
    end else begin
      revenue_q.push_back(best_revenue_for(len));
      n_solves++;
      if (len > longest_rod) longest_rod = len;
    end
  endtask

  // sender gap: mostly none, some short, a few long
  task automatic idle_gap();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 60) k = 0;
    else if (r < 95) k = $urandom_range(1, 3);
    else k = $urandom_range(8, 30);
    if (k != 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  // one random beat: mostly valid loads and short solves, a little noise
  // (dropped loads, rods past the table) and the odd long solve
  task automatic random_beat();
    int unsigned        r;
    logic [LEN_W-1:0]   len;
    logic [PRICE_W-1:0] px;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      r = $urandom_range(0, 99);
      if (r < 92) len = LEN_W'($urandom_range(1, MAX_LEN));
      else if (r < 95) len = '0;
      else len = LEN_W'($urandom_range(MAX_LEN + 1, 127));
      r = $urandom_range(0, 99);
      if (r < 5) px = '0;
      else if (r < 10) px = '1;
      else px = PRICE_W'($urandom);
      send_beat(CMD_LOAD, len, px);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) len = LEN_W'($urandom_range(0, 10));
      else if (r < 97) len = LEN_W'($urandom_range(11, 30));
      else len = LEN_W'($urandom_range(31, 127));
      // price is a don't-care on a solve, so it gets random bits
      send_beat(CMD_SOLVE, len, PRICE_W'($urandom));
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (revenue_q.size() != 0) @(posedge clk);
  endtask

  // edges of the fields: empty table, zero rod, dropped loads, full-scale
  // prices at both ends of the table, rods past the table, bit toggles
  task automatic test_directed_edges();
    send_beat(CMD_SOLVE, 7'd0,   16'h0000);  // zero rod
    send_beat(CMD_SOLVE, 7'd64,  16'hFFFF);  // all prices still zero
    send_beat(CMD_LOAD,  7'd0,   16'hFFFF);  // dropped
    send_beat(CMD_LOAD,  7'd65,  16'hFFFF);  // dropped
    send_beat(CMD_LOAD,  7'd127, 16'hFFFF);  // dropped
    send_beat(CMD_SOLVE, 7'd3,   16'h0000);  // proves the drops left no trace
    send_beat(CMD_LOAD,  7'd1,   16'hFFFF);
    send_beat(CMD_LOAD,  7'd64,  16'hFFFF);
    send_beat(CMD_SOLVE, 7'd1,   16'h0000);
    send_beat(CMD_SOLVE, 7'd64,  16'h0000);  // largest reachable revenue
    send_beat(CMD_SOLVE, 7'd127, 16'h0000);  // rod saturates to the table size
    send_beat(CMD_SOLVE, 7'd100, 16'h0000);
    send_beat(CMD_LOAD,  7'd1,   16'h0000);
    send_beat(CMD_LOAD,  7'd2,   16'h5555);
    send_beat(CMD_LOAD,  7'd3,   16'hAAAA);
    send_beat(CMD_SOLVE, 7'd0,   16'hFFFF);
    send_beat(CMD_SOLVE, 7'd2,   16'h0000);
    send_beat(CMD_SOLVE, 7'd3,   16'h0000);
    send_beat(CMD_SOLVE, 7'd6,   16'h0000);
    send_beat(CMD_LOAD,  7'd64,  16'h0000);
    send_beat(CMD_SOLVE, 7'd64,  16'h0000);
    idle_gap();
  endtask

  // bulk random traffic with random gaps on both sides
  task automatic test_random_mix();
    int unsigned target;
    target = n_loads + n_solves + 200;
    while (n_loads + n_solves < target) begin
      random_beat();
      idle_gap();
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the block backs up and stalls its input
  task automatic test_output_hold_off();
    hold_req = 400;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 2) send_beat(CMD_LOAD, LEN_W'($urandom_range(1, 8)), PRICE_W'($urandom));
      else send_beat(CMD_SOLVE, LEN_W'($urandom_range(1, 6)), PRICE_W'($urandom));
    end
    idle_gap();
  endtask

  // sender stops until everything owed has come back, then resumes
  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) begin
      random_beat();
      idle_gap();
    end
    wait_results_drained();
    for (int k = 0; k < 10; k++) begin
      random_beat();
      idle_gap();
    end
  endtask

  // no gaps on either side: beats every cycle the block allows
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int k = 0; k < 30; k++) random_beat();
    wait_results_drained();
    no_idle = 1'b0;
  endtask

  // result side stall generator
  initial begin : stall_gen
    int unsigned burst;
    int unsigned r;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        // long hold-off, counted here
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (burst != 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) burst = $urandom_range(8, 30);
        out_stall <= (r < 25);
      end
    end
  end

  // result checker: each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (revenue_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("%0t: result beat with nothing expected, best_revenue %0d",
                   $realtime, out_best_revenue);
      end else begin
        if (out_best_revenue !== revenue_q[0]) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: best_revenue mismatch, expected %0d, got %0d",
                     $realtime, revenue_q[0], out_best_revenue);
        end
        void'(revenue_q.pop_front());
        n_checked++;
      end
    end
  end

  // watchdog: too many cycles without a beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $realtime, idle_cycles, revenue_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    in_valid  <= 1'b0;
    in_cmd    <= CMD_LOAD;
    in_length <= '0;
    in_price  <= '0;
    rst_n     <= 1'b0;
    for (int k = 1; k <= MAX_LEN; k++) price_tab[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset shows up as input stall

    test_directed_edges();
    test_random_mix();
    test_output_hold_off();
    test_drain_pause();
    // the last test ends with every owed result back
    test_back_to_back();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d price loads, %0d dropped loads and %0d solves",
             n_loads, n_ignored, n_solves);
    $display("longest rod requested %0d, %0d results checked, %0d failures",
             longest_rod, n_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
